[src/lto_pkg.sv]
// Package for the LoRa time-on-air block: field widths, register indexes,
// reset values, pipeline depths and the reciprocal table of the symbol divider.
// No dependencies.
package lto_pkg;

    // Field widths
    localparam int LEN_W      = 8;
    localparam int SF_W       = 4;
    localparam int BW_W       = 19;
    localparam int CR_W       = 3;
    localparam int AIR_W      = 20;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;
    localparam logic [CFG_IDX_W-1:0] REG_SPREADING_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH_HZ     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODING_RATE      = 2'd2;

    // Reset values
    localparam logic [SF_W-1:0] SF_RESET = 4'd7;
    localparam logic [BW_W-1:0] BW_RESET = 19'd125000;
    localparam logic [CR_W-1:0] CR_RESET = 3'd1;

    // Internal widths
    localparam int NBITS_W    = 10;   // quarter-bit count plus rounding term
    localparam int DIVQ_W     = 4;    // symbol divisor in units of four bits
    localparam int RECIP_W    = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int CODED_W    = 10;
    localparam int QUARTER_W  = 15;
    localparam int SCALED_W   = 25;
    localparam int NUM_W      = 40;
    localparam int DEN_W      = 21;

    // Pipeline shape: five front stages, then one stage per quotient bit
    localparam int FRONT_STAGES = 5;
    localparam int DIV_STAGES   = AIR_W;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES;

    localparam logic [AIR_W-1:0] AIRTIME_MAX = 20'hFFFFF;

    // Rounded-up 2^16/d; exact floor division for numerators below 1024.
    function automatic logic [RECIP_W-1:0] recip(input logic [DIVQ_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            4'd10:   r = 17'd6554;
            4'd11:   r = 17'd5958;
            4'd12:   r = 17'd5462;
            4'd13:   r = 17'd5042;
            4'd14:   r = 17'd4682;
            4'd15:   r = 17'd4370;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

[src/lora_time_on_air_top.sv]
// LoRa time-on-air calculator: payload length in, airtime in milliseconds out.
// Depends on lto_pkg for widths, register indexes and the reciprocal table.
//
// Usage:
//   Input channel s_*: one beat carries a payload length in bytes.
//   Output channel m_*: one beat carries the airtime in whole milliseconds,
//   saturated to 20 bits (also when the bandwidth register is zero).
//   Configuration: cfg_wr_en, cfg_index and cfg_wdata write spreading factor
//   (index 0), bandwidth in Hz (index 1) and coding rate (index 2); other
//   indexes are ignored. Write only while no beat is in flight.
// Timing:
//   One beat is accepted per cycle while s_tready is high. A beat passes
//   five front stages for bit count, symbol count and scaling, then a
//   20-stage restoring divider that resolves one quotient bit per stage,
//   and its result is then written to the output register.
// Reset and stalls:
//   aresetn clears all valid bits and loads the registers with SF7, 125 kHz
//   and coding rate 4/5. When the receiver holds m_tready low, a skid
//   register catches one more result and the whole pipeline then freezes;
//   s_tready is low exactly while the skid register is full.
module lora_time_on_air_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [lto_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lto_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lto_pkg::S_TDATA_W-1:0]       s_tdata,   // [7:0] payload_len
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lto_pkg::M_TDATA_W-1:0]       m_tdata    // [19:0] airtime_ms, [23:20] zero
);

    localparam int DS = lto_pkg::DIV_STAGES;

    // Configuration registers
    logic [lto_pkg::SF_W-1:0] sf_reg;
    logic [lto_pkg::BW_W-1:0] bw_reg;
    logic [lto_pkg::CR_W-1:0] cr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sf_reg <= lto_pkg::SF_RESET;
            bw_reg <= lto_pkg::BW_RESET;
            cr_reg <= lto_pkg::CR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lto_pkg::REG_SPREADING_FACTOR: sf_reg <= cfg_wdata[lto_pkg::SF_W-1:0];
                lto_pkg::REG_BANDWIDTH_HZ:     bw_reg <= cfg_wdata[lto_pkg::BW_W-1:0];
                lto_pkg::REG_CODING_RATE:      cr_reg <= cfg_wdata[lto_pkg::CR_W-1:0];
                default: ;
            endcase
        end
    end

    // Values that follow from configuration alone. The user must change configuration
    // only while the pipeline is empty; the block does not enforce this. Every stage reads the registers directly.
    logic                          low_sf;
    logic [lto_pkg::SCALED_W-1:0]  chips_ms;
    logic                          ldro;
    logic [lto_pkg::DIVQ_W-1:0]    divq_raw;
    logic [lto_pkg::DIVQ_W-1:0]    divq;
    logic [lto_pkg::NBITS_W-1:0]   bits_base;
    logic [lto_pkg::QUARTER_W-1:0] quarter_base;
    logic [lto_pkg::DEN_W-1:0]     den;

    always_comb begin
        low_sf   = (sf_reg == 4'd5) || (sf_reg == 4'd6);
        chips_ms = {15'd0, 10'd1000} << sf_reg;
        ldro     = chips_ms >= {2'b00, bw_reg, 4'b0000};
        // Symbol divisor counted in groups of four bits
        if (ldro) begin
            divq_raw = (sf_reg > 4'd2) ? sf_reg - 4'd2 : 4'd0;
        end else begin
            divq_raw = sf_reg;
        end
        divq = (divq_raw == 4'd0) ? 4'd1 : divq_raw;
        // 16 header bits plus 20 fixed bits, plus the extra byte unless SF is 5 or 6, in quarters
        bits_base = low_sf ? 10'd9 : 10'd11;
        // Preamble plus overhead plus sync, in quarter symbols
        if (sf_reg <= 4'd8) begin
            quarter_base = low_sf ? 15'd185 : 15'd177;
        end else begin
            quarter_base = 15'd113;
        end
        den = {bw_reg, 2'b00};
    end

    // Pipeline advance: the whole pipeline moves while the skid register is empty
    logic skid_valid_reg;
    logic adv;
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    logic [lto_pkg::PIPE_DEPTH-1:0] pipe_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= '0;
        end else if (adv) begin
            pipe_valid_reg <= {pipe_valid_reg[lto_pkg::PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // Stage 1: payload bits in quarters, clamped at zero, plus rounding term
    logic [lto_pkg::NBITS_W-1:0] pos_q;
    logic [lto_pkg::NBITS_W-1:0] bits_q;
    logic [lto_pkg::NBITS_W-1:0] n_next;
    logic [lto_pkg::NBITS_W-1:0] n_reg;

    always_comb begin
        pos_q  = {1'b0, s_tdata[lto_pkg::LEN_W-1:0], 1'b0} + bits_base;
        bits_q = (pos_q > {6'd0, sf_reg}) ? pos_q - {6'd0, sf_reg} : '0;
        n_next = bits_q + {6'd0, divq} - 10'd1;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg <= n_next;
        end
    end

    // Stage 2: coded symbol groups by reciprocal multiply
    logic [lto_pkg::NBITS_W+lto_pkg::RECIP_W-1:0] recip_prod;
    logic [lto_pkg::CODED_W-1:0]                  coded_reg;

    assign recip_prod = {17'd0, n_reg} * {10'd0, lto_pkg::recip(divq)};

    always_ff @(posedge aclk) begin
        if (adv) begin
            coded_reg <= recip_prod[lto_pkg::RECIP_SHIFT +: lto_pkg::CODED_W];
        end
    end

    // Stage 3: total quarter symbols
    logic [lto_pkg::DIVQ_W-1:0]      cr_plus;
    logic [13:0]                     cr_prod;
    logic [lto_pkg::QUARTER_W:0]     quarter_sum;
    logic [lto_pkg::QUARTER_W-1:0]   quarters_reg;

    always_comb begin
        cr_plus     = {1'b0, cr_reg} + 4'd4;
        cr_prod     = {4'd0, coded_reg} * {10'd0, cr_plus};
        quarter_sum = {1'b0, quarter_base} + {cr_prod, 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            quarters_reg <= quarter_sum[lto_pkg::QUARTER_W-1:0];
        end
    end

    // Stage 4: scale by 1000 for milliseconds
    logic [lto_pkg::SCALED_W-1:0] scaled_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            scaled_reg <= {10'd0, quarters_reg} * 25'd1000;
        end
    end

    // Stage 5 and divider stages share these arrays; entry 0 is stage 5
    logic [lto_pkg::DEN_W-1:0] rem_reg [0:DS];
    logic [lto_pkg::AIR_W-1:0] low_reg [0:DS];
    logic [lto_pkg::AIR_W-1:0] quo_reg [0:DS];
    logic                      sat_reg [0:DS];

    // Stage 5: numerator shift by the chip count and early overflow check
    logic [lto_pkg::NUM_W-1:0] num;
    logic [lto_pkg::DEN_W-1:0] num_hi;

    always_comb begin
        num    = {15'd0, scaled_reg} << sf_reg;
        num_hi = {1'b0, num[lto_pkg::NUM_W-1:lto_pkg::AIR_W]};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= num_hi;
            low_reg[0] <= num[lto_pkg::AIR_W-1:0];
            quo_reg[0] <= '0;
            sat_reg[0] <= num_hi >= den;
        end
    end

    // Restoring divider: one quotient bit per stage, most significant first
    genvar k;
    generate
        for (k = 0; k < DS; k++) begin : g_div
            logic [lto_pkg::DEN_W:0]   trial;
            logic [lto_pkg::DEN_W:0]   diff;
            logic                      ge;

            always_comb begin
                trial = {rem_reg[k], low_reg[k][lto_pkg::AIR_W-1]};
                diff  = trial - {1'b0, den};
                ge    = trial >= {1'b0, den};
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[k+1] <= ge ? diff[lto_pkg::DEN_W-1:0]
                                       : trial[lto_pkg::DEN_W-1:0];
                    low_reg[k+1] <= {low_reg[k][lto_pkg::AIR_W-2:0], 1'b0};
                    quo_reg[k+1] <= {quo_reg[k][lto_pkg::AIR_W-2:0], ge};
                    sat_reg[k+1] <= sat_reg[k];
                end
            end
        end
    endgenerate

    // Pipeline result with saturation applied
    logic                      pipe_out_valid;
    logic [lto_pkg::AIR_W-1:0] pipe_out_air;

    assign pipe_out_valid = pipe_valid_reg[lto_pkg::PIPE_DEPTH-1];
    assign pipe_out_air   = sat_reg[DS] ? lto_pkg::AIRTIME_MAX : quo_reg[DS];

    // Output register and skid register
    logic                      m_valid_reg;
    logic [lto_pkg::AIR_W-1:0] m_air_reg;
    logic [lto_pkg::AIR_W-1:0] skid_air_reg;
    logic                      new_beat;
    logic                      out_free;

    assign new_beat = adv && pipe_out_valid;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                // Pipeline is frozen; drain the skid beat when the output frees
                if (m_tready) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (new_beat) begin
                if (out_free) begin
                    m_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_air_reg <= skid_air_reg;
            end
        end else if (new_beat) begin
            if (out_free) begin
                m_air_reg <= pipe_out_air;
            end else begin
                skid_air_reg <= pipe_out_air;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lto_pkg::M_TDATA_W-lto_pkg::AIR_W){1'b0}}, m_air_reg};

`ifndef SYNTHESIS
    // A full skid register always sits behind a valid output beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a beat while the output is empty");

    // The skid register only fills when the output beat was stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid register filled without an output stall");

    // While the pipeline is frozen, no valid bit moves or vanishes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> (pipe_valid_reg == $past(pipe_valid_reg)))
        else $error("pipeline valid bits changed during a freeze");

    // A new result never arrives while the skid register is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !new_beat)
        else $error("pipeline delivered a beat into a full skid register");
`endif

endmodule
